// ===== rtl/stig_pkg.sv =====
`timescale 1ns / 1ps

package stig_pkg;

  localparam int DEF_MAX_THETA = 256;
  localparam int DEF_MAX_PHI   = 256;

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int CFG_REGW = 9;
  localparam int IDXW     = 16;
  localparam int SATW     = 11;
  localparam int MIN_COUNT = 3;

  localparam logic [CFG_REGW-1:0] THETA_RESET = 9'd16;
  localparam logic [CFG_REGW-1:0] PHI_RESET   = 9'd16;

  localparam logic REG_THETA = 1'b0;
  localparam logic REG_PHI   = 1'b1;

  localparam logic [1:0] PH_SIDE  = 2'd0;
  localparam logic [1:0] PH_SEAM  = 2'd1;
  localparam logic [1:0] PH_NORTH = 2'd2;
  localparam logic [1:0] PH_SOUTH = 2'd3;

  typedef struct packed {
    logic [IDXW-1:0] vertex_a;
    logic [IDXW-1:0] vertex_b;
    logic [IDXW-1:0] vertex_c;
    logic            last;
  } face_t;

endpackage

// ===== rtl/stig_cfg.sv =====
`timescale 1ns / 1ps

module stig_cfg
  import stig_pkg::*;
#(
  parameter int MAX_THETA = DEF_MAX_THETA,
  parameter int MAX_PHI   = DEF_MAX_PHI,
  parameter int TW        = $clog2(MAX_THETA + 1),
  parameter int PW        = $clog2(MAX_PHI + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [TW-1:0]     eff_theta,
  output logic [PW-1:0]     eff_rings,
  output logic [IDXW-1:0]   npole,
  output logic              cfg_wr
);

  logic [CFG_REGW-1:0] theta_r;
  logic [CFG_REGW-1:0] phi_r;
  logic                wr_en;
  logic [SATW-1:0]     th_ext;
  logic [SATW-1:0]     ph_ext;
  logic [SATW-1:0]     th_sat;
  logic [SATW-1:0]     ph_sat;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_wr = wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_r <= THETA_RESET;
      phi_r   <= PHI_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_THETA: theta_r <= pwdata[CFG_REGW-1:0];
        REG_PHI:   phi_r   <= pwdata[CFG_REGW-1:0];
        default:   theta_r <= theta_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THETA: prdata = CFG_DW'(theta_r);
      REG_PHI:   prdata = CFG_DW'(phi_r);
      default:   prdata = '0;
    endcase
  end

  assign th_ext = SATW'(theta_r);
  assign ph_ext = SATW'(phi_r);

  always_comb begin
    if (th_ext < SATW'(MIN_COUNT)) begin
      th_sat = SATW'(MIN_COUNT);
    end else if (th_ext > SATW'(MAX_THETA)) begin
      th_sat = SATW'(MAX_THETA);
    end else begin
      th_sat = th_ext;
    end
    if (ph_ext < SATW'(MIN_COUNT)) begin
      ph_sat = SATW'(MIN_COUNT);
    end else if (ph_ext > SATW'(MAX_PHI)) begin
      ph_sat = SATW'(MAX_PHI);
    end else begin
      ph_sat = ph_ext;
    end
  end

  assign eff_theta = TW'(th_sat);
  assign eff_rings = PW'(ph_sat - SATW'(2));
  assign npole     = IDXW'(eff_rings) * IDXW'(eff_theta);

endmodule

// ===== rtl/stig_seq.sv =====
`timescale 1ns / 1ps

module stig_seq
  import stig_pkg::*;
#(
  parameter int MAX_THETA = DEF_MAX_THETA,
  parameter int MAX_PHI   = DEF_MAX_PHI,
  parameter int TW        = $clog2(MAX_THETA + 1),
  parameter int PW        = $clog2(MAX_PHI + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic            restart,
  input  logic            cfg_wr,
  input  logic [TW-1:0]   eff_theta,
  input  logic [PW-1:0]   eff_rings,
  input  logic [IDXW-1:0] npole,
  output face_t           face
);

  logic [1:0]      phase_r, phase_nxt;
  logic [TW-1:0]   col_r, col_nxt;
  logic [PW-1:0]   ring_r, ring_nxt;
  logic            half_r, half_nxt;
  logic [IDXW-1:0] base_r, base_nxt;
  logic            pend_r;

  logic            rs;
  logic [1:0]      start_ph;
  logic [1:0]      ph;
  logic [TW-1:0]   col;
  logic [PW-1:0]   ring;
  logic            half;
  logic [IDXW-1:0] base;
  logic [IDXW-1:0] t16, tm1, f1, f2, i16;
  logic [TW:0]     col_inc, t_ext;
  logic [PW:0]     ring_inc, r_ext;

  assign rs       = restart | pend_r;
  assign start_ph = (eff_rings >= PW'(2)) ? PH_SIDE : PH_NORTH;
  assign ph       = rs ? start_ph : phase_r;
  assign col      = rs ? '0 : col_r;
  assign ring     = rs ? '0 : ring_r;
  assign half     = rs ? 1'b0 : half_r;
  assign base     = rs ? '0 : base_r;

  assign t16      = IDXW'(eff_theta);
  assign tm1      = t16 - IDXW'(1);
  assign f1       = base;
  assign f2       = base + t16;
  assign i16      = IDXW'(col);
  assign col_inc  = {1'b0, col} + (TW+1)'(1);
  assign t_ext    = {1'b0, eff_theta};
  assign ring_inc = {1'b0, ring} + (PW+1)'(1);
  assign r_ext    = {1'b0, eff_rings};

  always_comb begin
    phase_nxt = ph;
    col_nxt   = col;
    ring_nxt  = ring;
    half_nxt  = half;
    base_nxt  = base;
    face      = '0;
    unique case (ph)
      PH_SIDE: begin
        if (!half) begin
          face.vertex_a = f2 + i16;
          face.vertex_b = f1 + i16 + IDXW'(1);
          face.vertex_c = f1 + i16;
          half_nxt      = 1'b1;
        end else begin
          face.vertex_a = f1 + i16 + IDXW'(1);
          face.vertex_b = f2 + i16;
          face.vertex_c = f2 + i16 + IDXW'(1);
          half_nxt      = 1'b0;
          col_nxt       = col_inc[TW-1:0];
          if (col_inc >= t_ext - (TW+1)'(1)) begin
            col_nxt  = '0;
            ring_nxt = ring_inc[PW-1:0];
            base_nxt = base + t16;
            if (ring_inc >= r_ext - (PW+1)'(1)) begin
              phase_nxt = PH_SEAM;
              ring_nxt  = '0;
              base_nxt  = '0;
            end
          end
        end
      end
      PH_SEAM: begin
        if (!half) begin
          face.vertex_a = f2 + tm1;
          face.vertex_b = f1;
          face.vertex_c = f1 + tm1;
          half_nxt      = 1'b1;
        end else begin
          face.vertex_a = f1;
          face.vertex_b = f2 + tm1;
          face.vertex_c = f2;
          half_nxt      = 1'b0;
          ring_nxt      = ring_inc[PW-1:0];
          base_nxt      = base + t16;
          if (ring_inc >= r_ext - (PW+1)'(1)) begin
            phase_nxt = PH_NORTH;
            ring_nxt  = '0;
            base_nxt  = '0;
            col_nxt   = '0;
          end
        end
      end
      PH_NORTH: begin
        face.vertex_a = npole;
        if (col_inc < t_ext) begin
          face.vertex_b = i16;
          face.vertex_c = i16 + IDXW'(1);
        end else begin
          face.vertex_b = tm1;
          face.vertex_c = '0;
        end
        col_nxt = col_inc[TW-1:0];
        if (col_inc >= t_ext) begin
          phase_nxt = PH_SOUTH;
          col_nxt   = '0;
          base_nxt  = npole - t16;
        end
      end
      PH_SOUTH: begin
        face.vertex_a = npole + IDXW'(1);
        if (col_inc < t_ext) begin
          face.vertex_b = f1 + i16 + IDXW'(1);
          face.vertex_c = f1 + i16;
        end else begin
          face.vertex_b = f1;
          face.vertex_c = f1 + tm1;
          face.last     = 1'b1;
        end
        col_nxt = col_inc[TW-1:0];
        if (col_inc >= t_ext) begin
          phase_nxt = start_ph;
          col_nxt   = '0;
          ring_nxt  = '0;
          half_nxt  = 1'b0;
          base_nxt  = '0;
        end
      end
      default: face = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIDE;
      col_r   <= '0;
      ring_r  <= '0;
      half_r  <= 1'b0;
      base_r  <= '0;
      pend_r  <= 1'b1;
    end else begin
      if (step) begin
        phase_r <= phase_nxt;
        col_r   <= col_nxt;
        ring_r  <= ring_nxt;
        half_r  <= half_nxt;
        base_r  <= base_nxt;
      end
      if (cfg_wr) begin
        pend_r <= 1'b1;
      end else if (step) begin
        pend_r <= 1'b0;
      end
    end
  end

  a_last_south: assert property (@(posedge clk) disable iff (!rst_n)
    face.last |-> ph == PH_SOUTH)
    else $error("last flag outside south fan");

  a_wrap_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && face.last && !cfg_wr |=> col_r == '0 && base_r == '0 && !half_r)
    else $error("sequence did not wrap after last triangle");

  a_half_quads: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> (phase_r == PH_SIDE || phase_r == PH_SEAM))
    else $error("second half set in a fan phase");

endmodule

// ===== rtl/stig_outbuf.sv =====
`timescale 1ns / 1ps

module stig_outbuf
  import stig_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_stall,
  input  face_t face_i,
  output logic  out_valid,
  input  logic  out_stall,
  output face_t face_o
);

  logic  out_valid_r;
  logic  skid_valid_r;
  face_t out_data_r;
  face_t skid_data_r;
  logic  push;
  logic  pop;

  assign push_stall = skid_valid_r;
  assign push       = push_valid & ~skid_valid_r;
  assign pop        = out_valid_r & ~out_stall;
  assign out_valid  = out_valid_r;
  assign face_o     = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r <= face_i;
      end else begin
        skid_data_r <= face_i;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a request while output is empty");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> !skid_valid_r && out_valid_r)
    else $error("skid did not drain into output");

endmodule

// ===== rtl/sphere_triangle_index_generator.sv =====
`timescale 1ns / 1ps
// Triangle index sequencer for a latitude-longitude sphere.
// Each request on the in_ channel (in_valid, in_stall, in_restart) returns one
// triangle on the out_ channel: three vertex indices and a last flag that marks
// the final triangle of the sphere, after which the sequence wraps to the first.
// in_restart high restarts the sequence and returns the first triangle.
// One request per cycle while in_stall is low. The result appears in out_valid
// the cycle after acceptance unless the output is held; the counters advance
// once per accepted request and the triangle is formed in the same cycle.
// When out_stall holds the output, one more request is held in a skid register;
// in_stall then rises until the output drains.
// theta_count (address 0) and phi_count (address 4) are written over the APB
// port; the user writes them only while idle, which the block does not enforce.
// Any write to either register restarts the sequence. Reset: both registers
// return to 16, the output empties, the next request returns the first triangle.

module sphere_triangle_index_generator
  import stig_pkg::*;
#(
  parameter int MAX_THETA = DEF_MAX_THETA,
  parameter int MAX_PHI   = DEF_MAX_PHI
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDXW-1:0]   out_vertex_a,
  output logic [IDXW-1:0]   out_vertex_b,
  output logic [IDXW-1:0]   out_vertex_c,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int TW = $clog2(MAX_THETA + 1);
  localparam int PW = $clog2(MAX_PHI + 1);

  logic [TW-1:0]   eff_theta;
  logic [PW-1:0]   eff_rings;
  logic [IDXW-1:0] npole;
  logic            cfg_wr;
  logic            step;
  face_t           face;
  face_t           face_q;

  assign step = in_valid & ~in_stall;

  stig_cfg #(
    .MAX_THETA (MAX_THETA),
    .MAX_PHI   (MAX_PHI),
    .TW        (TW),
    .PW        (PW)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .eff_theta (eff_theta),
    .eff_rings (eff_rings),
    .npole     (npole),
    .cfg_wr    (cfg_wr)
  );

  stig_seq #(
    .MAX_THETA (MAX_THETA),
    .MAX_PHI   (MAX_PHI),
    .TW        (TW),
    .PW        (PW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .restart   (in_restart),
    .cfg_wr    (cfg_wr),
    .eff_theta (eff_theta),
    .eff_rings (eff_rings),
    .npole     (npole),
    .face      (face)
  );

  stig_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .face_i     (face),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .face_o     (face_q)
  );

  assign out_vertex_a = face_q.vertex_a;
  assign out_vertex_b = face_q.vertex_b;
  assign out_vertex_c = face_q.vertex_c;
  assign out_last     = face_q.last;

endmodule

// ===== test/sphere_triangle_index_generator_tb.sv =====
`timescale 1ns / 1ps

module sphere_triangle_index_generator_tb;
  import stig_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_AW-1:0] ADDR_THETA = {REG_THETA, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_PHI   = {REG_PHI, 2'b00};

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic              in_restart = 1'b0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [IDXW-1:0]   out_vertex_a;
  logic [IDXW-1:0]   out_vertex_b;
  logic [IDXW-1:0]   out_vertex_c;
  logic              out_last;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [CFG_AW-1:0] paddr      = '0;
  logic [CFG_DW-1:0] pwdata     = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  sphere_triangle_index_generator uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_vertex_a(out_vertex_a),
    .out_vertex_b(out_vertex_b),
    .out_vertex_c(out_vertex_c),
    .out_last(out_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // sphere state mirror
  logic [CFG_REGW-1:0] theta_reg = THETA_RESET;
  logic [CFG_REGW-1:0] phi_reg   = PHI_RESET;
  logic [1:0]          face_phase = PH_SIDE;
  int unsigned         ring_idx   = 0;
  int unsigned         col_idx    = 0;
  bit                  upper_tri  = 1'b0;
  int unsigned         ring_first = 0;

  face_t pending_faces[$];
  int    fail_count    = 0;
  int    send_idle_pct = 0;
  int    stall_pct     = 0;
  int    cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_count(logic [CFG_REGW-1:0] v, int unsigned hi);
    if (v < MIN_COUNT) return MIN_COUNT;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_sphere();
    int unsigned r;
    r = clamp_count(phi_reg, DEF_MAX_PHI) - 2;
    face_phase = (r >= 2) ? PH_SIDE : PH_NORTH;
    ring_idx   = 0;
    col_idx    = 0;
    upper_tri  = 1'b0;
    ring_first = 0;
  endfunction

  function automatic face_t next_face(bit restart);
    int unsigned t, r, i, f1, f2, a, b, c;
    face_t f;
    t = clamp_count(theta_reg, DEF_MAX_THETA);
    r = clamp_count(phi_reg, DEF_MAX_PHI) - 2;
    a = 0;
    b = 0;
    c = 0;
    f.last = 1'b0;
    if (restart) restart_sphere();
    i  = col_idx;
    f1 = ring_first;
    f2 = ring_first + t;
    case (face_phase)
      PH_SIDE: begin
        if (!upper_tri) begin
          a = f2 + i; b = f1 + i + 1; c = f1 + i;
          upper_tri = 1'b1;
        end else begin
          a = f1 + i + 1; b = f2 + i; c = f2 + i + 1;
          upper_tri = 1'b0;
          col_idx++;
          if (col_idx >= t - 1) begin
            col_idx = 0;
            ring_idx++;
            ring_first += t;
            if (ring_idx >= r - 1) begin
              face_phase = PH_SEAM;
              ring_idx   = 0;
              ring_first = 0;
            end
          end
        end
      end
      PH_SEAM: begin
        if (!upper_tri) begin
          a = f2 + t - 1; b = f1; c = f1 + t - 1;
          upper_tri = 1'b1;
        end else begin
          a = f1; b = f2 + t - 1; c = f2;
          upper_tri = 1'b0;
          ring_idx++;
          ring_first += t;
          if (ring_idx >= r - 1) begin
            face_phase = PH_NORTH;
            ring_idx   = 0;
            ring_first = 0;
            col_idx    = 0;
          end
        end
      end
      PH_NORTH: begin
        a = r * t;
        if (i < t - 1) begin
          b = i; c = i + 1;
        end else begin
          b = t - 1; c = 0;
        end
        col_idx++;
        if (col_idx >= t) begin
          face_phase = PH_SOUTH;
          col_idx    = 0;
          ring_first = (r - 1) * t;
        end
      end
      default: begin
        a = r * t + 1;
        if (i < t - 1) begin
          b = f1 + i + 1; c = f1 + i;
        end else begin
          b = f1; c = f1 + t - 1;
          f.last = 1'b1;
        end
        col_idx++;
        if (col_idx >= t) restart_sphere();
      end
    endcase
    f.vertex_a = a[IDXW-1:0];
    f.vertex_b = b[IDXW-1:0];
    f.vertex_c = c[IDXW-1:0];
    return f;
  endfunction

  function automatic void check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, actual %0d", name, expected, actual);
      fail_count++;
    end
  endfunction

  // check each accepted triangle, drive result back-pressure
  always @(posedge clk) begin
    face_t exp_face;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_faces.size() == 0) begin
        $error("unexpected triangle: %0d %0d %0d last %0d",
               out_vertex_a, out_vertex_b, out_vertex_c, out_last);
        fail_count++;
      end else begin
        exp_face = pending_faces.pop_front();
        check_field("vertex_a", exp_face.vertex_a, out_vertex_a);
        check_field("vertex_b", exp_face.vertex_b, out_vertex_b);
        check_field("vertex_c", exp_face.vertex_c, out_vertex_c);
        check_field("last", exp_face.last, out_last);
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_request(bit restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid   <= 1'b0;
      in_restart <= $urandom_range(1);
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    pending_faces.push_back(next_face(restart));
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_faces.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic read_reg(logic [CFG_AW-1:0] addr, string name, logic [CFG_REGW-1:0] expected);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field(name, {{(CFG_DW-CFG_REGW){1'b0}}, expected}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_THETA) theta_reg = data[CFG_REGW-1:0];
    else phi_reg = data[CFG_REGW-1:0];
    restart_sphere();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    read_reg(addr, (addr == ADDR_THETA) ? "theta_count" : "phi_count", data[CFG_REGW-1:0]);
  endtask

  task automatic set_sphere(logic [CFG_REGW-1:0] theta, logic [CFG_REGW-1:0] phi);
    drain_requests();
    write_reg(ADDR_THETA, {$urandom_range(1) ? 23'($urandom) : 23'd0, theta});
    write_reg(ADDR_PHI, {$urandom_range(1) ? 23'($urandom) : 23'd0, phi});
  endtask

  task automatic test_default_sphere();
    read_reg(ADDR_THETA, "theta_count", THETA_RESET);
    read_reg(ADDR_PHI, "phi_count", PHI_RESET);
    repeat (4) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
  endtask

  task automatic test_single_ring();
    set_sphere(9'd3, 9'd3);
    repeat (7) send_request(1'b0);
  endtask

  task automatic test_saturated_counts();
    set_sphere(9'd0, 9'd2);
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    set_sphere(9'd511, 9'd4);
    repeat (3) send_request(1'b0);
    send_request(1'b1);
  endtask

  task automatic test_mid_sequence_write();
    set_sphere(9'd3, 9'd4);
    repeat (3) send_request(1'b0);
    drain_requests();
    write_reg(ADDR_THETA, 32'd4);
    repeat (2) send_request(1'b0);
  endtask

  function automatic logic [CFG_REGW-1:0] extreme_count();
    case ($urandom_range(3))
      0: return CFG_REGW'($urandom_range(2));
      1: return CFG_REGW'(256);
      2: return CFG_REGW'($urandom_range(257, 511));
      default: return CFG_REGW'(MIN_COUNT);
    endcase
  endfunction

  task automatic test_random_spheres(int idle_pct, int stall_level, int item_count);
    int sent;
    int burst;
    int total;
    logic [CFG_REGW-1:0] theta, phi;
    send_idle_pct = idle_pct;
    stall_pct     = stall_level;
    sent = 0;
    while (sent < item_count) begin
      if ($urandom_range(99) < 85) begin
        theta = CFG_REGW'($urandom_range(3, 9));
        phi   = CFG_REGW'($urandom_range(3, 7));
        total = 2 * theta * (phi - 2);
        burst = total + $urandom_range(total);
      end else begin
        theta = extreme_count();
        phi   = extreme_count();
        burst = $urandom_range(20, 80);
      end
      if ($urandom_range(9) == 0) begin
        drain_requests();
        write_reg($urandom_range(1) ? ADDR_THETA : ADDR_PHI, CFG_DW'(theta));
      end else begin
        set_sphere(theta, phi);
      end
      repeat (burst) begin
        send_request($urandom_range(99) < 4);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 12;
    stall_pct     = 65;
    test_default_sphere();
    test_single_ring();
    test_saturated_counts();
    test_mid_sequence_write();
    test_random_spheres(12, 65, 560);
    test_random_spheres(65, 12, 560);
    test_random_spheres(0, 0, 560);
    drain_requests();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sphere_triangle_index_generator.f =====
rtl/stig_pkg.sv
rtl/stig_cfg.sv
rtl/stig_seq.sv
rtl/stig_outbuf.sv
rtl/sphere_triangle_index_generator.sv
test/sphere_triangle_index_generator_tb.sv
